// ===== rtl/pctr_pkg.sv =====
package pctr_pkg;

    localparam int CLUSTER_COUNT     = 4;
    localparam int SLOTS_PER_CLUSTER = 16;
    localparam int TREE_SIZE         = 512;
    localparam int ROWS_PER_TREE     = 8;
    localparam int ROW_BITS          = 32;

    localparam int TOTAL_SLOTS = CLUSTER_COUNT * SLOTS_PER_CLUSTER;
    localparam int SLOT_IDX_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int FREE_W      = $clog2(TREE_SIZE + 1);
    localparam int ROW_SHIFT   = $clog2(ROWS_PER_TREE);

    localparam int FUNC_W     = 3;
    localparam int CLUSTER_W  = 2;
    localparam int SLOT_W     = 4;
    localparam int TREE_W     = 29;
    localparam int FRAMES_W   = 10;
    localparam int NEW_ROW_W  = 32;
    localparam int OUT_FREE_W = 10;
    localparam int OUT_ROW_W  = 32;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int SUM_W  = ((FREE_W > FRAMES_W) ? FREE_W : FRAMES_W) + 1;
    localparam int TCMP_W = ROW_BITS + TREE_W;

    localparam logic [FUNC_W-1:0] OP_GET       = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUT       = 3'd1;
    localparam logic [FUNC_W-1:0] OP_SET_START = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SWAP      = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DRAIN     = 3'd4;
    localparam logic [FUNC_W-1:0] OP_FREE_INC  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FREE_RESERVE_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD  = 1'd1;

    localparam logic               FREE_RESERVE_EN_RST = 1'b1;
    localparam logic [THRESH_W-1:0] FREE_THRESHOLD_RST = 16'd4;

    typedef struct packed {
        logic                 present;
        logic [FREE_W-1:0]    free;
        logic [ROW_BITS-1:0]  row;
    } resv_entry_t;

    typedef struct packed {
        logic [TREE_W-1:0]   tree;
        logic [THRESH_W-1:0] count;
    } hist_entry_t;

    localparam int RESV_W = $bits(resv_entry_t);
    localparam int HIST_W = $bits(hist_entry_t);

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [CLUSTER_W-1:0] cluster;
        logic [SLOT_W-1:0]    slot;
        logic                 tree_given;
        logic [TREE_W-1:0]    tree;
        logic [FRAMES_W-1:0]  frames;
        logic [NEW_ROW_W-1:0] new_row;
    } req_t;

    typedef struct packed {
        logic                  success;
        logic                  old_present;
        logic [CLUSTER_W-1:0]  out_cluster;
        logic [OUT_FREE_W-1:0] old_free;
        logic [OUT_ROW_W-1:0]  old_row;
    } rsp_t;

    typedef struct packed {
        logic resv_we;
        logic hist_we;
    } upd_t;

    function automatic logic slot_in_range(logic [CLUSTER_W-1:0] cluster,
                                           logic [SLOT_W-1:0] slot);
        return (int'(cluster) < CLUSTER_COUNT) && (int'(slot) < SLOTS_PER_CLUSTER);
    endfunction

    function automatic logic [SLOT_IDX_W-1:0] slot_index(logic [CLUSTER_W-1:0] cluster,
                                                         logic [SLOT_W-1:0] slot);
        return SLOT_IDX_W'(int'(cluster) * SLOTS_PER_CLUSTER + int'(slot));
    endfunction

endpackage

// ===== rtl/pctr_if.sv =====
interface pctr_req_if;
    logic                           valid;
    logic                           ready;
    logic [pctr_pkg::FUNC_W-1:0]    func;
    logic [pctr_pkg::CLUSTER_W-1:0] cluster;
    logic [pctr_pkg::SLOT_W-1:0]    slot;
    logic                           tree_given;
    logic [pctr_pkg::TREE_W-1:0]    tree;
    logic [pctr_pkg::FRAMES_W-1:0]  frames;
    logic [pctr_pkg::NEW_ROW_W-1:0] new_row;

    modport source (output valid, func, cluster, slot, tree_given, tree, frames, new_row,
                    input ready);
    modport sink (input valid, func, cluster, slot, tree_given, tree, frames, new_row,
                  output ready);
endinterface

interface pctr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            success;
    logic                            old_present;
    logic [pctr_pkg::CLUSTER_W-1:0]  out_cluster;
    logic [pctr_pkg::OUT_FREE_W-1:0] old_free;
    logic [pctr_pkg::OUT_ROW_W-1:0]  old_row;

    modport source (output valid, success, old_present, out_cluster, old_free, old_row,
                    input ready);
    modport sink (input valid, success, old_present, out_cluster, old_free, old_row,
                  output ready);
endinterface

// ===== rtl/pctr_ram.sv =====
module pctr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as reset value
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/pctr_op_unit.sv =====
module pctr_op_unit (
    input  pctr_pkg::req_t                     req,
    input  pctr_pkg::resv_entry_t              old_resv,
    input  pctr_pkg::hist_entry_t              old_hist,
    input  logic                               free_reserve_enable,
    input  logic [pctr_pkg::THRESH_W-1:0]      free_threshold,
    output pctr_pkg::resv_entry_t              new_resv,
    output pctr_pkg::hist_entry_t              new_hist,
    output pctr_pkg::upd_t                     upd,
    output pctr_pkg::rsp_t                     rsp
);

    logic                              in_range;
    logic                              tree_match;
    logic                              row_same_tree;
    logic [pctr_pkg::ROW_BITS-1:0]     masked_row;
    logic [pctr_pkg::SUM_W-1:0]        free_ext;
    logic [pctr_pkg::SUM_W-1:0]        frames_ext;
    logic [pctr_pkg::SUM_W-1:0]        put_sum;
    logic [pctr_pkg::SUM_W-1:0]        size_ext;
    logic [pctr_pkg::ROW_BITS+pctr_pkg::TREE_W-1:0] swap_row;

    always_comb
    begin
        in_range   = pctr_pkg::slot_in_range(req.cluster, req.slot);
        masked_row = pctr_pkg::ROW_BITS'(req.new_row);
        tree_match = pctr_pkg::TCMP_W'(old_resv.row >> pctr_pkg::ROW_SHIFT)
                     == pctr_pkg::TCMP_W'(req.tree);
        row_same_tree = (old_resv.row >> pctr_pkg::ROW_SHIFT)
                        == (masked_row >> pctr_pkg::ROW_SHIFT);
        free_ext   = pctr_pkg::SUM_W'(old_resv.free);
        frames_ext = pctr_pkg::SUM_W'(req.frames);
        size_ext   = pctr_pkg::SUM_W'(pctr_pkg::TREE_SIZE);
        put_sum    = free_ext + frames_ext;
        swap_row   = pctr_pkg::TCMP_W'(req.tree) << pctr_pkg::ROW_SHIFT;

        new_resv        = old_resv;
        new_hist        = old_hist;
        upd             = '0;
        rsp.success     = 1'b0;
        rsp.old_present = old_resv.present;
        rsp.out_cluster = req.cluster;
        rsp.old_free    = pctr_pkg::OUT_FREE_W'(old_resv.free);
        rsp.old_row     = pctr_pkg::OUT_ROW_W'(old_resv.row);

        case (req.func)
            pctr_pkg::OP_GET:
            begin
                if (old_resv.present && (!req.tree_given || tree_match)
                    && (free_ext >= frames_ext))
                begin
                    new_resv.free = pctr_pkg::FREE_W'(free_ext - frames_ext);
                    upd.resv_we   = 1'b1;
                    rsp.success   = 1'b1;
                end
            end
            pctr_pkg::OP_PUT:
            begin
                if (old_resv.present && tree_match)
                begin
                    new_resv.free = (put_sum > size_ext) ? pctr_pkg::FREE_W'(size_ext)
                                                         : pctr_pkg::FREE_W'(put_sum);
                    upd.resv_we   = 1'b1;
                    rsp.success   = 1'b1;
                end
            end
            pctr_pkg::OP_SET_START:
            begin
                if (old_resv.present && row_same_tree)
                begin
                    new_resv.row = masked_row;
                    upd.resv_we  = 1'b1;
                    rsp.success  = 1'b1;
                end
            end
            pctr_pkg::OP_SWAP:
            begin
                new_resv.present = 1'b1;
                new_resv.free    = (frames_ext > size_ext) ? pctr_pkg::FREE_W'(size_ext)
                                                           : pctr_pkg::FREE_W'(frames_ext);
                new_resv.row     = pctr_pkg::ROW_BITS'(swap_row);
                upd.resv_we      = 1'b1;
                rsp.success      = 1'b1;
            end
            pctr_pkg::OP_DRAIN:
            begin
                new_resv    = '0;
                upd.resv_we = 1'b1;
                rsp.success = old_resv.present;
            end
            pctr_pkg::OP_FREE_INC:
            begin
                rsp.old_present = 1'b0;
                rsp.old_free    = '0;
                rsp.old_row     = '0;
                if (free_reserve_enable)
                begin
                    if (old_hist.tree != req.tree)
                    begin
                        new_hist.tree  = req.tree;
                        new_hist.count = '0;
                        upd.hist_we    = 1'b1;
                    end
                    else if (old_hist.count < free_threshold)
                    begin
                        new_hist.count = old_hist.count + pctr_pkg::THRESH_W'(1);
                        upd.hist_we    = 1'b1;
                    end
                    else
                    begin
                        rsp.success = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // drop out-of-range slots
        if (!in_range)
        begin
            upd             = '0;
            rsp.success     = 1'b0;
            rsp.old_present = 1'b0;
            rsp.old_free    = '0;
            rsp.old_row     = '0;
        end
    end

endmodule

// ===== rtl/per_core_tree_reservation_table.sv =====
// channel | dir | handshake     | word
// req     | in  | valid / ready | func, cluster, slot, tree_given, tree, frames, new_row
// rsp     | out | valid / ready | success, old_present, out_cluster, old_free, old_row
// cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// Each word is handled in order: accepting it reads the slot and history memories,
// and the modify stage then modifies, writes back and loads the output register.
// A new word is taken once the previous one has been written back.
// A stalled rsp holds the working word; reset clears all slots at once.
module per_core_tree_reservation_table (
    input  logic                            clk,
    input  logic                            rst_n,
    pctr_req_if.sink                        req,
    pctr_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [pctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pctr_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                              free_reserve_enable_reg;
    logic [pctr_pkg::THRESH_W-1:0]     free_threshold_reg;
    logic                              s1_valid_reg;
    pctr_pkg::req_t                    s1_req_reg;
    logic                              out_valid_reg;
    pctr_pkg::rsp_t                    out_reg;

    pctr_pkg::req_t                    in_req;
    logic                              accept;
    logic                              complete;
    logic [pctr_pkg::SLOT_IDX_W-1:0]   rd_idx;
    logic [pctr_pkg::SLOT_IDX_W-1:0]   wr_idx;
    logic [pctr_pkg::RESV_W-1:0]       resv_rd;
    logic [pctr_pkg::HIST_W-1:0]       hist_rd;
    pctr_pkg::resv_entry_t             new_resv;
    pctr_pkg::hist_entry_t             new_hist;
    pctr_pkg::upd_t                    upd;
    pctr_pkg::rsp_t                    op_rsp;
    logic                              resv_we;
    logic                              hist_we;

    assign in_req.func       = req.func;
    assign in_req.cluster    = req.cluster;
    assign in_req.slot       = req.slot;
    assign in_req.tree_given = req.tree_given;
    assign in_req.tree       = req.tree;
    assign in_req.frames     = req.frames;
    assign in_req.new_row    = req.new_row;

    assign req.ready = !s1_valid_reg;
    assign accept    = req.valid && req.ready;
    assign complete  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign rd_idx    = pctr_pkg::slot_index(in_req.cluster, in_req.slot);
    assign wr_idx    = pctr_pkg::slot_index(s1_req_reg.cluster, s1_req_reg.slot);
    assign resv_we   = complete && upd.resv_we;
    assign hist_we   = complete && upd.hist_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reserve_enable_reg <= pctr_pkg::FREE_RESERVE_EN_RST;
            free_threshold_reg      <= pctr_pkg::FREE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pctr_pkg::REG_FREE_RESERVE_EN: free_reserve_enable_reg <= cfg_data[0];
                pctr_pkg::REG_FREE_THRESHOLD:
                    free_threshold_reg <= pctr_pkg::THRESH_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (complete)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (complete)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= in_req;
        end
        if (complete)
        begin
            out_reg <= op_rsp;
        end
    end

    pctr_ram #(
        .WIDTH (pctr_pkg::RESV_W),
        .DEPTH (pctr_pkg::TOTAL_SLOTS)
    ) u_resv_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .rd_data (resv_rd),
        .wr_en   (resv_we),
        .wr_addr (wr_idx),
        .wr_data (new_resv)
    );

    pctr_ram #(
        .WIDTH (pctr_pkg::HIST_W),
        .DEPTH (pctr_pkg::TOTAL_SLOTS)
    ) u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .rd_data (hist_rd),
        .wr_en   (hist_we),
        .wr_addr (wr_idx),
        .wr_data (new_hist)
    );

    pctr_op_unit u_op_unit (
        .req                 (s1_req_reg),
        .old_resv            (resv_rd),
        .old_hist            (hist_rd),
        .free_reserve_enable (free_reserve_enable_reg),
        .free_threshold      (free_threshold_reg),
        .new_resv            (new_resv),
        .new_hist            (new_hist),
        .upd                 (upd),
        .rsp                 (op_rsp)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.success     = out_reg.success;
    assign rsp.old_present = out_reg.old_present;
    assign rsp.out_cluster = out_reg.out_cluster;
    assign rsp.old_free    = out_reg.old_free;
    assign rsp.old_row     = out_reg.old_row;

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not reach the modify stage");

    a_complete_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> out_valid_reg)
        else $error("completed word not presented on rsp");

    a_write_only_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (resv_we || hist_we) |-> complete && !(resv_we && hist_we))
        else $error("memory write outside a completing word");

    a_free_inc_keeps_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (complete && s1_req_reg.func == pctr_pkg::OP_FREE_INC) |-> !resv_we)
        else $error("free_inc wrote the reservation store");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !complete) |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("stalled word lost from the modify stage");

endmodule

// ===== sim/per_core_tree_reservation_table_tb.sv =====
module per_core_tree_reservation_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pctr_pkg::TREE_W-1:0] TREE_MAX = {pctr_pkg::TREE_W{1'b1}};
    localparam int NUM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 217;
    localparam int CALM_WORDS = 150;

    typedef struct {
        bit                          present;
        bit [pctr_pkg::FREE_W-1:0]   free;
        bit [pctr_pkg::ROW_BITS-1:0] row;
    } slot_state_t;

    typedef struct {
        bit [pctr_pkg::TREE_W-1:0]   tree;
        bit [pctr_pkg::THRESH_W-1:0] count;
    } hist_state_t;

    typedef struct {
        pctr_pkg::req_t w;
        bit             known;
        pctr_pkg::rsp_t rsp;
    } directed_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [pctr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pctr_pkg::CFG_DATA_W-1:0] cfg_data;

    pctr_req_if req_bus();
    pctr_rsp_if rsp_bus();

    slot_state_t                 slot_state[pctr_pkg::TOTAL_SLOTS];
    hist_state_t                 free_hist[pctr_pkg::TOTAL_SLOTS];
    bit                          reserve_en;
    bit [pctr_pkg::THRESH_W-1:0] threshold;

    pctr_pkg::rsp_t pending_results[$];
    directed_row_t  directed[$];
    int             hot_slot[4];
    int             mismatches;
    bit             calm;

    per_core_tree_reservation_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int slot_of(pctr_pkg::req_t w);
        return int'(w.cluster) * pctr_pkg::SLOTS_PER_CLUSTER + int'(w.slot);
    endfunction

    function automatic bit [pctr_pkg::TREE_W-1:0] tree_of_row(
        bit [pctr_pkg::ROW_BITS-1:0] row);
        return pctr_pkg::TREE_W'(row >> pctr_pkg::ROW_SHIFT);
    endfunction

    function automatic bit [pctr_pkg::FREE_W-1:0] clamp_free(int unsigned v);
        return (v > pctr_pkg::TREE_SIZE) ? pctr_pkg::FREE_W'(pctr_pkg::TREE_SIZE)
                                         : pctr_pkg::FREE_W'(v);
    endfunction

    function automatic pctr_pkg::rsp_t apply_table_op(pctr_pkg::req_t w);
        pctr_pkg::rsp_t r;
        int             idx;
        slot_state_t    prev;
        int unsigned    total;
        idx = slot_of(w);
        prev = slot_state[idx];
        r = '0;
        r.out_cluster = w.cluster;
        r.old_present = prev.present;
        r.old_free = prev.free;
        r.old_row = prev.row;
        case (w.func)
            pctr_pkg::OP_GET:
                if (prev.present && (!w.tree_given || tree_of_row(prev.row) == w.tree)
                    && prev.free >= w.frames)
                begin
                    slot_state[idx].free = prev.free - w.frames;
                    r.success = 1'b1;
                end
            pctr_pkg::OP_PUT:
                if (prev.present && tree_of_row(prev.row) == w.tree)
                begin
                    total = prev.free + w.frames;
                    slot_state[idx].free = clamp_free(total);
                    r.success = 1'b1;
                end
            pctr_pkg::OP_SET_START:
                if (prev.present && tree_of_row(prev.row) == tree_of_row(w.new_row))
                begin
                    slot_state[idx].row = w.new_row;
                    r.success = 1'b1;
                end
            pctr_pkg::OP_SWAP:
            begin
                slot_state[idx].present = 1'b1;
                slot_state[idx].free = clamp_free(w.frames);
                slot_state[idx].row =
                    pctr_pkg::ROW_BITS'(64'(w.tree) * pctr_pkg::ROWS_PER_TREE);
                r.success = 1'b1;
            end
            pctr_pkg::OP_DRAIN:
            begin
                slot_state[idx] = '{1'b0, '0, '0};
                r.success = prev.present;
            end
            pctr_pkg::OP_FREE_INC:
            begin
                r.old_present = 1'b0;
                r.old_free = '0;
                r.old_row = '0;
                if (reserve_en)
                begin
                    if (free_hist[idx].tree != w.tree)
                        free_hist[idx] = '{w.tree, '0};
                    else if (free_hist[idx].count < threshold)
                        free_hist[idx].count++;
                    else
                        r.success = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic pctr_pkg::req_t pick_word();
        pctr_pkg::req_t w;
        int             idx;
        int             roll;
        idx = ($urandom_range(0, 99) < 60) ? hot_slot[$urandom_range(0, 3)]
                                            : $urandom_range(0, pctr_pkg::TOTAL_SLOTS - 1);
        w.cluster = pctr_pkg::CLUSTER_W'(idx / pctr_pkg::SLOTS_PER_CLUSTER);
        w.slot = pctr_pkg::SLOT_W'(idx % pctr_pkg::SLOTS_PER_CLUSTER);
        roll = $urandom_range(0, 99);
        if (roll < 25)
            w.func = pctr_pkg::OP_GET;
        else if (roll < 45)
            w.func = pctr_pkg::OP_PUT;
        else if (roll < 58)
            w.func = pctr_pkg::OP_SET_START;
        else if (roll < 70)
            w.func = pctr_pkg::OP_SWAP;
        else if (roll < 75)
            w.func = pctr_pkg::OP_DRAIN;
        else if (roll < 96)
            w.func = pctr_pkg::OP_FREE_INC;
        else
            w.func = pctr_pkg::FUNC_W'($urandom_range(int'(pctr_pkg::OP_FREE_INC) + 1,
                                                      (1 << pctr_pkg::FUNC_W) - 1));
        roll = $urandom_range(0, 99);
        if (roll < 70)
            w.tree = (w.func == pctr_pkg::OP_FREE_INC) ? free_hist[idx].tree
                                                       : tree_of_row(slot_state[idx].row);
        else if (roll < 85)
            w.tree = pctr_pkg::TREE_W'($urandom_range(0, 3));
        else
            w.tree = pctr_pkg::TREE_W'($urandom);
        w.tree_given = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 50)
            w.frames = pctr_pkg::FRAMES_W'($urandom_range(0, 16));
        else if (roll < 80)
            w.frames = pctr_pkg::FRAMES_W'($urandom_range(0, pctr_pkg::TREE_SIZE));
        else
            w.frames = pctr_pkg::FRAMES_W'($urandom_range(0, (1 << pctr_pkg::FRAMES_W) - 1));
        if ($urandom_range(0, 99) < 70)
            w.new_row = (slot_state[idx].row & ~32'(pctr_pkg::ROWS_PER_TREE - 1))
                        | 32'($urandom_range(0, pctr_pkg::ROWS_PER_TREE - 1));
        else
            w.new_row = $urandom;
        return w;
    endfunction

    task automatic add_row(input logic [pctr_pkg::FUNC_W-1:0] func, input int cluster,
                           input int slot, input bit tree_given,
                           input logic [pctr_pkg::TREE_W-1:0] tree, input int frames,
                           input logic [pctr_pkg::NEW_ROW_W-1:0] new_row,
                           input bit known = 1'b0, input pctr_pkg::rsp_t rsp = '0);
        directed_row_t row;
        row.w = '{func, pctr_pkg::CLUSTER_W'(cluster), pctr_pkg::SLOT_W'(slot), tree_given,
                  tree, pctr_pkg::FRAMES_W'(frames), new_row};
        row.known = known;
        row.rsp = rsp;
        directed.push_back(row);
    endtask

    task automatic idle_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                @(negedge clk);
                req_bus.valid = 1'b0;
            end
        end
    endtask

    task automatic send_word(input pctr_pkg::req_t w, input bit known,
                             input pctr_pkg::rsp_t typed);
        pctr_pkg::rsp_t predicted;
        @(negedge clk);
        req_bus.func = w.func;
        req_bus.cluster = w.cluster;
        req_bus.slot = w.slot;
        req_bus.tree_given = w.tree_given;
        req_bus.tree = w.tree;
        req_bus.frames = w.frames;
        req_bus.new_row = w.new_row;
        req_bus.valid = 1'b1;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        predicted = apply_table_op(w);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic write_reg(input logic [pctr_pkg::CFG_IDX_W-1:0] index,
                             input logic [pctr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == pctr_pkg::REG_FREE_RESERVE_EN)
            reserve_en = value[0];
        else if (index == pctr_pkg::REG_FREE_THRESHOLD)
            threshold = pctr_pkg::THRESH_W'(value);
    endtask

    // stall the result side in bursts
    initial
    begin
        int stall_len;
        rsp_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_len = $urandom_range(1, 10);
                rsp_bus.ready = 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
            else
                rsp_bus.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pctr_pkg::rsp_t got;
        pctr_pkg::rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.success, rsp_bus.old_present, rsp_bus.out_cluster,
                    rsp_bus.old_free, rsp_bus.old_row};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: s=%0d p=%0d c=%0d free=%0d row=%h",
                             got.success, got.old_present, got.out_cluster,
                             got.old_free, got.old_row);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.success !== want.success || got.old_present !== want.old_present
                    || got.out_cluster !== want.out_cluster
                    || got.old_free !== want.old_free || got.old_row !== want.old_row)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: want s=%0d p=%0d c=%0d free=%0d row=%h, ",
                               want.success, want.old_present, want.out_cluster,
                               want.old_free, want.old_row);
                        $display("got s=%0d p=%0d c=%0d free=%0d row=%h",
                                 got.success, got.old_present, got.out_cluster,
                                 got.old_free, got.old_row);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [pctr_pkg::CFG_DATA_W-1:0] en_data[NUM_PHASES];
        logic [pctr_pkg::CFG_DATA_W-1:0] thr_data[NUM_PHASES];
        pctr_pkg::req_t w;
        int             sent;
        int             run_len;
        int             idx;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.func = pctr_pkg::OP_GET;
        req_bus.cluster = '0;
        req_bus.slot = '0;
        req_bus.tree_given = 1'b0;
        req_bus.tree = '0;
        req_bus.frames = '0;
        req_bus.new_row = '0;
        mismatches = 0;
        calm = 1'b0;
        reserve_en = pctr_pkg::FREE_RESERVE_EN_RST;
        threshold = pctr_pkg::FREE_THRESHOLD_RST;
        foreach (slot_state[i])
        begin
            slot_state[i] = '{1'b0, '0, '0};
            free_hist[i] = '{'0, '0};
        end

        en_data = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h0001};
        thr_data = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd3};

        add_row(pctr_pkg::OP_GET, 0, 0, 1'b0, '0, 0, '0, 1'b1,
                '{1'b0, 1'b0, 2'd0, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_PUT, 0, 0, 1'b0, '0, 0, '0, 1'b1,
                '{1'b0, 1'b0, 2'd0, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_SET_START, 0, 0, 1'b0, '0, 0, 32'd3, 1'b1,
                '{1'b0, 1'b0, 2'd0, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_DRAIN, 0, 0, 1'b0, '0, 0, '0, 1'b1,
                '{1'b0, 1'b0, 2'd0, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_FREE_INC, 3, 15, 1'b0, '0, 0, '0, 1'b1,
                '{1'b0, 1'b0, 2'd3, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_SWAP, 0, 0, 1'b1, TREE_MAX, 1023, '1, 1'b1,
                '{1'b1, 1'b0, 2'd0, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_GET, 0, 0, 1'b1, TREE_MAX, pctr_pkg::TREE_SIZE, '0, 1'b1,
                '{1'b1, 1'b1, 2'd0, 10'd512, 32'hFFFF_FFF8});
        add_row(pctr_pkg::OP_GET, 0, 0, 1'b0, '0, 1, '0);
        add_row(pctr_pkg::OP_PUT, 0, 0, 1'b0, TREE_MAX, 1023, '0);
        add_row(pctr_pkg::OP_PUT, 0, 0, 1'b0, TREE_MAX - 1, 5, '0);
        add_row(pctr_pkg::OP_GET, 0, 0, 1'b1, '0, 1, '0);
        add_row(pctr_pkg::OP_SET_START, 0, 0, 1'b0, '0, 0, 32'hFFFF_FFFF);
        add_row(pctr_pkg::OP_SET_START, 0, 0, 1'b0, '0, 0, 32'h0000_0000);
        add_row(pctr_pkg::OP_SWAP, 3, 15, 1'b0, '0, 0, '0);
        add_row(pctr_pkg::OP_SET_START, 3, 15, 1'b0, '0, 0, 32'd7);
        add_row(pctr_pkg::OP_FREE_INC + 3'(1), 0, 0, 1'b1, TREE_MAX, 1023, '1);
        add_row(pctr_pkg::OP_FREE_INC + 3'(2), 3, 15, 1'b0, '0, 0, '0);
        add_row(pctr_pkg::OP_DRAIN, 0, 0, 1'b0, '0, 0, '0);
        add_row(pctr_pkg::OP_FREE_INC, 1, 5, 1'b0, TREE_MAX, 0, '0);
        repeat (4) add_row(pctr_pkg::OP_FREE_INC, 1, 5, 1'b0, TREE_MAX, 0, '0);
        add_row(pctr_pkg::OP_FREE_INC, 1, 5, 1'b0, TREE_MAX, 0, '0, 1'b1,
                '{1'b1, 1'b0, 2'd1, 10'd0, 32'd0});
        add_row(pctr_pkg::OP_FREE_INC, 1, 5, 1'b0, '0, 0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            idle_gap();
            send_word(directed[i].w, directed[i].known, directed[i].rsp);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_reg(pctr_pkg::REG_FREE_RESERVE_EN, en_data[phase]);
            write_reg(pctr_pkg::REG_FREE_THRESHOLD, thr_data[phase]);
            foreach (hot_slot[i])
                hot_slot[i] = $urandom_range(0, pctr_pkg::TOTAL_SLOTS - 1);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                if (phase == NUM_PHASES - 1 && sent >= WORDS_PER_PHASE - CALM_WORDS)
                    calm = 1'b1;
                w = pick_word();
                if ($urandom_range(0, 9) == 0)
                begin
                    // run of frees to one tree, to walk the history up to the hint
                    idx = slot_of(w);
                    w.func = pctr_pkg::OP_FREE_INC;
                    if ($urandom_range(0, 3) != 0)
                        w.tree = free_hist[idx].tree;
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                    begin
                        idle_gap();
                        send_word(w, 1'b0, '0);
                        sent++;
                    end
                end
                else
                begin
                    idle_gap();
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
        end

        @(negedge clk);
        req_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
